// ===== rtl/core/crcfc_pkg.sv =====
// Shared constants, queue entry type and CRC-32 byte update for the frame checker.
package crcfc_pkg;

  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [7:0]  ACK_CODE      = 8'h79;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Header byte positions, little-endian fields.
  localparam logic [3:0] HDR_CODE     = 4'd0;
  localparam logic [3:0] HDR_STATUS   = 4'd1;
  localparam logic [3:0] HDR_LEN_LO   = 4'd2;
  localparam logic [3:0] HDR_LEN_HI   = 4'd3;
  localparam logic [3:0] HDR_SEQ_LO   = 4'd4;
  localparam logic [3:0] HDR_SEQ_HI   = 4'd5;
  localparam logic [3:0] HDR_DET_B0   = 4'd6;
  localparam logic [3:0] HDR_DET_B1   = 4'd7;
  localparam logic [3:0] HDR_DET_B2   = 4'd8;
  localparam logic [3:0] HDR_DET_B3   = 4'd9;
  localparam logic [3:0] HDR_CRC_B0   = 4'd10;
  localparam logic [3:0] HDR_CRC_B1   = 4'd11;
  localparam logic [3:0] HDR_CRC_B2   = 4'd12;
  localparam logic [3:0] HDR_LAST     = 4'd13;

  typedef struct packed {
    logic        has_payload;
    logic [7:0]  payload;
    logic        has_summary;
    logic [7:0]  code;
    logic [7:0]  status;
    logic [15:0] length;
    logic [15:0] sequence_num;
    logic [31:0] detail;
    logic        crc_good;
    logic        ack;
  } entry_t;

  // Reflected CRC-32 update over one byte, eight shift/xor steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/crcfc_front.sv =====
// Front end: accepts received bytes, parses the header, runs the CRC and queues results.
module crcfc_front import crcfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        q_full,
  output logic        push,
  output entry_t      push_entry
);

  logic [3:0]  header_index;
  logic        in_payload;
  logic [15:0] payload_remaining;
  logic [31:0] running_crc;
  logic [7:0]  held_code;
  logic [7:0]  held_status;
  logic [15:0] held_length;
  logic [15:0] held_sequence;
  logic [31:0] held_detail;
  logic [31:0] held_received_crc;

  logic        accept;
  logic [31:0] crc_upd;
  logic [31:0] full_received_crc;
  logic        last_payload;
  logic        empty_frame_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign crc_upd  = crc_byte(running_crc, rx_byte);
  assign full_received_crc = {rx_byte, held_received_crc[23:0]};
  assign last_payload      = in_payload && (payload_remaining == 16'd1);
  assign empty_frame_end   = !in_payload && (header_index == HDR_LAST) && (held_length == 16'd0);

  assign push = accept && (in_payload || empty_frame_end);

  always_comb begin
    push_entry              = '0;
    push_entry.has_payload  = in_payload;
    push_entry.payload      = rx_byte;
    push_entry.has_summary  = last_payload || empty_frame_end;
    push_entry.code         = held_code;
    push_entry.status       = held_status;
    push_entry.length       = held_length;
    push_entry.sequence_num = held_sequence;
    push_entry.detail       = held_detail;
    push_entry.ack          = (held_code == ACK_CODE);
    if (in_payload) begin
      push_entry.crc_good = (~crc_upd == held_received_crc);
    end else begin
      push_entry.crc_good = (~running_crc == full_received_crc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index      <= '0;
      in_payload        <= 1'b0;
      payload_remaining <= '0;
      running_crc       <= CRC_INIT;
      held_code         <= '0;
      held_status       <= '0;
      held_length       <= '0;
      held_sequence     <= '0;
      held_detail       <= '0;
      held_received_crc <= '0;
    end else if (accept) begin
      if (in_payload) begin
        payload_remaining <= payload_remaining - 16'd1;
        if (last_payload) begin
          in_payload  <= 1'b0;
          running_crc <= CRC_INIT;
        end else begin
          running_crc <= crc_upd;
        end
      end else begin
        if (header_index < HDR_CRC_B0) begin
          running_crc <= crc_upd;
        end
        case (header_index)
          HDR_CODE:   held_code            <= rx_byte;
          HDR_STATUS: held_status          <= rx_byte;
          HDR_LEN_LO: held_length[7:0]     <= rx_byte;
          HDR_LEN_HI: held_length[15:8]    <= rx_byte;
          HDR_SEQ_LO: held_sequence[7:0]   <= rx_byte;
          HDR_SEQ_HI: held_sequence[15:8]  <= rx_byte;
          HDR_DET_B0: held_detail[7:0]     <= rx_byte;
          HDR_DET_B1: held_detail[15:8]    <= rx_byte;
          HDR_DET_B2: held_detail[23:16]   <= rx_byte;
          HDR_DET_B3: held_detail[31:24]   <= rx_byte;
          HDR_CRC_B0: held_received_crc[7:0]   <= rx_byte;
          HDR_CRC_B1: held_received_crc[15:8]  <= rx_byte;
          HDR_CRC_B2: held_received_crc[23:16] <= rx_byte;
          default:    held_received_crc[31:24] <= rx_byte;
        endcase
        if (header_index == HDR_LAST) begin
          header_index <= '0;
          if (held_length == 16'd0) begin
            running_crc <= CRC_INIT;
          end else begin
            in_payload        <= 1'b1;
            payload_remaining <= held_length;
          end
        end else begin
          header_index <= header_index + 4'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/crcfc_queue.sv =====
// Short result queue between the front end and the output stage.
module crcfc_queue import crcfc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/crcfc_back.sv =====
// Output stage: turns queue entries into payload and summary beats in a register.
module crcfc_back import crcfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  entry_t      head_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  frame_code,
  output logic [7:0]  frame_status,
  output logic [15:0] payload_length,
  output logic [15:0] sequence_res,
  output logic [31:0] detail_word,
  output logic        crc_good,
  output logic        acknowledged,
  output logic        last_of_frame
);

  // Set once the payload beat of an entry that also carries a summary has been loaded.
  logic phase;
  logic load;
  logic send_payload;

  assign load         = head_valid && (!out_valid || out_ready);
  assign send_payload = head_entry.has_payload && !phase;
  assign pop          = load && !(send_payload && head_entry.has_summary);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= send_payload && head_entry.has_summary;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_payload) begin
        result_kind    <= 1'b0;
        payload_byte   <= head_entry.payload;
        frame_code     <= '0;
        frame_status   <= '0;
        payload_length <= '0;
        sequence_res   <= '0;
        detail_word    <= '0;
        crc_good       <= 1'b0;
        acknowledged   <= 1'b0;
        last_of_frame  <= 1'b0;
      end else begin
        result_kind    <= 1'b1;
        payload_byte   <= '0;
        frame_code     <= head_entry.code;
        frame_status   <= head_entry.status;
        payload_length <= head_entry.length;
        sequence_res   <= head_entry.sequence_num;
        detail_word    <= head_entry.detail;
        crc_good       <= head_entry.crc_good;
        acknowledged   <= head_entry.ack;
        last_of_frame  <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/crc32_response_frame_checker.sv =====
// Top level of the CRC-32 checked response frame checker.
// The input channel (in_valid/in_ready/rx_byte) takes one received byte per beat.
// Each frame is a 14-byte little-endian header (code, status, length, sequence,
// detail word, received CRC) followed by as many payload bytes as the length says.
// The output channel (out_valid/out_ready) gives one result per beat: a payload
// beat for each payload byte, and a summary beat with the header fields, the CRC
// match flag and the acknowledge flag at the end of every frame.
// Header bytes give no beat, except the last one of a zero-length frame.
// A byte accepted by the front end is written into the queue and from there
// loaded into the output register, where its result beat can be taken. Input
// throughput is one byte per cycle while the queue is not full; the byte-wide
// CRC update in the front end is combinational. The last payload byte of a
// frame makes two output beats.
// A queue of QUEUE_DEPTH entries sits between the parser and the output
// register; when the receiver stalls, the queue fills and in_ready drops only
// once it is full. A synchronous reset empties the queue, drops out_valid, and
// puts the parser back at the first header byte with the CRC at all ones.
module crc32_response_frame_checker import crcfc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  frame_code,
  output logic [7:0]  frame_status,
  output logic [15:0] payload_length,
  output logic [15:0] sequence_res,
  output logic [31:0] detail_word,
  output logic        crc_good,
  output logic        acknowledged,
  output logic        last_of_frame
);

  // Queue handshake between the parser and the output stage.
  logic   q_full;
  logic   q_push;
  entry_t q_push_entry;
  logic   q_pop;
  logic   q_head_valid;
  entry_t q_head_entry;

  // The parser owns all frame state and pushes one entry per byte that yields results.
  crcfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  crcfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry)
  );

  // The output stage splits an entry for the last payload byte into two beats.
  crcfc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (q_head_valid),
    .head_entry     (q_head_entry),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .frame_code     (frame_code),
    .frame_status   (frame_status),
    .payload_length (payload_length),
    .sequence_res   (sequence_res),
    .detail_word    (detail_word),
    .crc_good       (crc_good),
    .acknowledged   (acknowledged),
    .last_of_frame  (last_of_frame)
  );

endmodule

// ===== sim/crc32_response_frame_checker_test.sv =====
// Self-checking testbench for the CRC-32 response frame checker, driven byte by byte.
`timescale 1ns / 100ps

module crc32_response_frame_checker_test import crcfc_pkg::*;;

  // The run stops here even if the block hangs.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Quiet cycles after the last expected beat, to catch stray output beats.
  localparam int unsigned SETTLE_WAIT  = 32;
  localparam int unsigned RANDOM_BYTES = 450;
  localparam int unsigned MAX_REPORTS  = 10;

  // One expected output beat, in the order of the output ports.
  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    logic [7:0]  code;
    logic [7:0]  status;
    logic [15:0] length;
    logic [15:0] seq;
    logic [31:0] detail;
    logic        crc_match;
    logic        ack;
    logic        last;
  } frame_result_t;

  // One byte waiting to be sent. When hold_back is set, the sender first
  // waits until every output beat that it expects has arrived.
  typedef struct {
    logic [7:0] data;
    bit         hold_back;
  } wire_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  frame_code;
  logic [7:0]  frame_status;
  logic [15:0] payload_length;
  logic [15:0] sequence_res;
  logic [31:0] detail_word;
  logic        crc_good;
  logic        acknowledged;
  logic        last_of_frame;

  crc32_response_frame_checker u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .frame_code     (frame_code),
    .frame_status   (frame_status),
    .payload_length (payload_length),
    .sequence_res   (sequence_res),
    .detail_word    (detail_word),
    .crc_good       (crc_good),
    .acknowledged   (acknowledged),
    .last_of_frame  (last_of_frame)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Bytes still to be sent, and output beats predicted but not yet seen.
  wire_byte_t    rx_backlog[$];
  frame_result_t expected_results[$];

  // The predicted count is only touched by the sender's block (blocking);
  // the checked count only by the receiver's block (nonblocking). Comparing
  // them from either side therefore never depends on process order.
  int unsigned results_predicted = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Own copy of the frame parser state.
  logic [3:0]  hdr_pos;
  logic        in_body;
  logic [15:0] body_left;
  logic [31:0] crc_acc;
  logic [7:0]  seen_code;
  logic [7:0]  seen_status;
  logic [15:0] seen_length;
  logic [15:0] seen_seq;
  logic [31:0] seen_detail;
  logic [31:0] seen_crc;

  // Reflected CRC-32 over one byte, taking the data bits LSB first.
  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) c = {1'b0, c[31:1]} ^ CRC_POLY;
      else c = {1'b0, c[31:1]};
    end
    return c;
  endfunction

  task automatic parser_reset();
    hdr_pos = HDR_CODE;
    in_body = 1'b0;
    body_left = 16'd0;
    crc_acc = CRC_INIT;
    seen_code = 8'h00;
    seen_status = 8'h00;
    seen_length = 16'd0;
    seen_seq = 16'd0;
    seen_detail = 32'd0;
    seen_crc = 32'd0;
  endtask

  task automatic push_result(input frame_result_t r);
    expected_results.push_back(r);
    results_predicted++;
  endtask

  // The end-of-frame beat. The held header fields survive it; only the
  // parse position and the CRC register start over.
  task automatic push_summary();
    frame_result_t r;
    r = '0;
    r.kind = 1'b1;
    r.code = seen_code;
    r.status = seen_status;
    r.length = seen_length;
    r.seq = seen_seq;
    r.detail = seen_detail;
    r.crc_match = (~crc_acc == seen_crc);
    r.ack = (seen_code == ACK_CODE);
    r.last = 1'b1;
    push_result(r);
    hdr_pos = HDR_CODE;
    in_body = 1'b0;
    body_left = 16'd0;
    crc_acc = CRC_INIT;
  endtask

  // Works out the beats caused by one accepted byte.
  task automatic predict_byte(input logic [7:0] b);
    frame_result_t r;
    if (in_body) begin
      crc_acc = crc32_step(crc_acc, b);
      r = '0;
      r.body_byte = b;
      push_result(r);
      body_left = body_left - 16'd1;
      // The last payload byte gives two beats: the byte, then the summary.
      if (body_left == 16'd0) push_summary();
    end else begin
      // The four received CRC bytes are not covered by the CRC.
      if (hdr_pos < HDR_CRC_B0) crc_acc = crc32_step(crc_acc, b);
      case (hdr_pos)
        HDR_CODE:   seen_code = b;
        HDR_STATUS: seen_status = b;
        HDR_LEN_LO: seen_length[7:0] = b;
        HDR_LEN_HI: seen_length[15:8] = b;
        HDR_SEQ_LO: seen_seq[7:0] = b;
        HDR_SEQ_HI: seen_seq[15:8] = b;
        HDR_DET_B0: seen_detail[7:0] = b;
        HDR_DET_B1: seen_detail[15:8] = b;
        HDR_DET_B2: seen_detail[23:16] = b;
        HDR_DET_B3: seen_detail[31:24] = b;
        HDR_CRC_B0: seen_crc[7:0] = b;
        HDR_CRC_B1: seen_crc[15:8] = b;
        HDR_CRC_B2: seen_crc[23:16] = b;
        default:    seen_crc[31:24] = b;
      endcase
      if (hdr_pos == HDR_LAST) begin
        hdr_pos = HDR_CODE;
        // A zero-length frame is summarized on its last header byte.
        if (seen_length == 16'd0) begin
          push_summary();
        end else begin
          in_body = 1'b1;
          body_left = seen_length;
        end
      end else begin
        hdr_pos = hdr_pos + 4'd1;
      end
    end
  endtask

  // Queues one frame. The CRC field is computed over the bytes actually
  // sent and is then spoiled by one flipped bit unless crc_ok is set.
  // body_fill below zero means random payload bytes. sent_body may be less
  // than len, leaving the frame unfinished.
  task automatic queue_frame(input logic [7:0] code, input logic [7:0] status,
                             input logic [15:0] len, input logic [15:0] seq,
                             input logic [31:0] detail, input bit crc_ok,
                             input bit hold_back, input int sent_body, input int body_fill);
    logic [7:0]  hdr [14];
    logic [7:0]  body [$];
    logic [31:0] crc;
    wire_byte_t  w;
    hdr[0] = code;
    hdr[1] = status;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    hdr[4] = seq[7:0];
    hdr[5] = seq[15:8];
    hdr[6] = detail[7:0];
    hdr[7] = detail[15:8];
    hdr[8] = detail[23:16];
    hdr[9] = detail[31:24];
    crc = CRC_INIT;
    for (int i = 0; i < 10; i++) crc = crc32_step(crc, hdr[i]);
    for (int i = 0; i < sent_body; i++) begin
      body.push_back((body_fill < 0) ? 8'($urandom_range(0, 255)) : 8'(body_fill));
      crc = crc32_step(crc, body[i]);
    end
    crc = ~crc;
    if (!crc_ok) crc = crc ^ (32'h1 << $urandom_range(0, 31));
    hdr[10] = crc[7:0];
    hdr[11] = crc[15:8];
    hdr[12] = crc[23:16];
    hdr[13] = crc[31:24];
    for (int i = 0; i < 14; i++) begin
      w.data = hdr[i];
      w.hold_back = hold_back && (i == 0);
      rx_backlog.push_back(w);
    end
    foreach (body[i]) begin
      w.data = body[i];
      w.hold_back = 1'b0;
      rx_backlog.push_back(w);
    end
  endtask

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  // Checks the beat on the output ports against the oldest expectation.
  task automatic check_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      note_failure($sformatf("output beat with nothing expected (kind %0d)", result_kind));
      return;
    end
    want = expected_results.pop_front();
    compare_field("result_kind", want.kind, result_kind);
    compare_field("payload_byte", want.body_byte, payload_byte);
    compare_field("frame_code", want.code, frame_code);
    compare_field("frame_status", want.status, frame_status);
    compare_field("payload_length", want.length, payload_length);
    compare_field("sequence_res", want.seq, sequence_res);
    compare_field("detail_word", want.detail, detail_word);
    compare_field("crc_good", want.crc_match, crc_good);
    compare_field("acknowledged", want.ack, acknowledged);
    compare_field("last_of_frame", want.last, last_of_frame);
  endtask

  // Sender. A beat is accepted when in_valid and in_ready are both high at
  // an edge; it is predicted right there. Before each byte the sender
  // idles for a drawn number of cycles, and now and then it switches into
  // a calm stretch where it sends back to back.
  int unsigned send_gap = 0;
  bit          send_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte <= 8'h00;
      send_gap <= 0;
      parser_reset();
    end else begin
      if (in_valid && in_ready) predict_byte(rx_byte);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (rx_backlog.size() != 0 &&
                     (!rx_backlog[0].hold_back || results_checked == results_predicted)) begin
          in_valid <= 1'b1;
          rx_byte <= rx_backlog[0].data;
          if ($urandom_range(0, 39) == 0) send_calm <= !send_calm;
          send_gap <= send_calm ? 0 : $urandom_range(0, 8);
          void'(rx_backlog.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. After each accepted beat it draws the length of a stall during
  // which out_ready stays low, with calm stretches as on the sender.
  int unsigned recv_gap = 0;
  int unsigned stall_draw;
  bit          recv_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
      results_checked <= 0;
    end else if (out_valid && out_ready) begin
      check_result();
      results_checked <= results_checked + 1;
      if ($urandom_range(0, 39) == 0) recv_calm <= !recv_calm;
      stall_draw = recv_calm ? 0 : $urandom_range(0, 8);
      if (stall_draw == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        recv_gap <= stall_draw - 1;
      end
    end else if (recv_gap != 0) begin
      out_ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("crc32_response_frame_checker verification failed");
      $finish;
    end
  end

  int unsigned pick;
  logic [15:0] rand_len;

  initial begin
    // Directed frames. An acknowledged empty frame with a good CRC and all
    // other fields zero; an empty frame with every field at its maximum and
    // a bad CRC; one payload byte of zero; two bytes of all ones with a code
    // one off the acknowledge value and a bad CRC.
    queue_frame(ACK_CODE, 8'h00, 16'd0, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, 0, -1);
    queue_frame(8'hFF, 8'hFF, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, -1);
    queue_frame(ACK_CODE, 8'h00, 16'd1, 16'h0001, 32'h8000_0001, 1'b1, 1'b1, 1, 8'h00);
    queue_frame(8'h78, 8'h80, 16'd2, 16'h8000, 32'h7FFF_FFFF, 1'b0, 1'b0, 2, 8'hFF);

    // Random frames, mostly short ones. A few open with a pause until the
    // output side has caught up. Early on, one long frame whose length
    // needs the high length byte, always behind such a pause.
    while (rx_backlog.size() < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) rand_len = 16'd0;
      else if (pick < 90) rand_len = 16'($urandom_range(1, 20));
      else rand_len = 16'($urandom_range(21, 60));
      queue_frame($urandom_range(0, 1) ? ACK_CODE : 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), rand_len, 16'($urandom_range(0, 65535)),
                  $urandom, $urandom_range(0, 9) < 7, $urandom_range(0, 9) == 0,
                  rand_len, -1);
      if (rx_backlog.size() >= RANDOM_BYTES / 4 && rx_backlog.size() < RANDOM_BYTES / 4 + 80)
        queue_frame(ACK_CODE, 8'($urandom_range(0, 255)), 16'd260,
                    16'($urandom_range(0, 65535)), $urandom, 1'b1, 1'b1, 260, -1);
    end

    // The largest length can only be started: a frame of 0xFFFF bytes is
    // out of reach, so the run ends a few payload bytes into it.
    queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'hFFFF,
                16'($urandom_range(0, 65535)), $urandom, 1'b1, 1'b1, 6, -1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every byte sent and accepted, then every predicted beat seen, then a
    // quiet stretch in which any extra beat would be flagged.
    @(posedge clk);
    while (rx_backlog.size() != 0 || in_valid) @(posedge clk);
    while (results_checked != results_predicted) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    if (expected_results.size() != 0)
      note_failure($sformatf("%0d output beats never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("crc32_response_frame_checker verification clean");
    end else begin
      $display("crc32_response_frame_checker verification failed");
    end
    $finish;
  end

endmodule
